// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CHK_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CHK_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== rtl/falru_pkg.sv =====
// Shared types and constants of the fully associative LRU directory.
package falru_pkg;

  localparam int ENTRIES  = 64;
  localparam int KEY_BITS = 32;
  localparam int RANK_W   = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int CAP_W    = 7;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = ADDR_W - 2;

  localparam logic [IDX_W-1:0] REG_CAPACITY = IDX_W'(0);
  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(64);

  localparam logic FUNC_ACCESS = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [RANK_W-1:0]   rank_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [CAP_W-1:0]    cap_t;

endpackage

// ===== rtl/fully_associative_lru_directory.sv =====
// Fully associative LRU directory: key match, recency ranking and eviction.
//
// Requests arrive on req_valid/req_ready with func (0 access, 1 remove) and key.
// Each request word produces exactly one response word on rsp_valid/rsp_ready
// carrying hit, evicted_valid, victim_key, remove_error and occupancy.
// A request is captured in an input register; from there all entries compare
// their keys in parallel, and as it advances the ranks are updated at once and
// the response is written to the output register, which raises rsp_valid.
// One request is taken every cycle while the receiver takes responses. The
// throughput is set by the match and rank update, which each request needs
// before the next one can look up.
// When the receiver stalls, the response is held and the input register keeps
// its word; req_ready drops once both are full. The capacity register sits at
// byte address 0 of the APB-style port; the user must write it only while no
// request is in flight, as the block does not enforce this. Reset empties the
// directory, clears both registers' valid flags and sets the capacity to 64.
module fully_associative_lru_directory (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  logic                    func,
  input  falru_pkg::key_t         key,
  output logic                    rsp_valid,
  input  logic                    rsp_ready,
  output logic                    hit,
  output logic                    evicted_valid,
  output falru_pkg::key_t         victim_key,
  output logic                    remove_error,
  output falru_pkg::cnt_t         occupancy,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [falru_pkg::ADDR_W-1:0] paddr,
  input  logic [falru_pkg::DATA_W-1:0] pwdata,
  output logic [falru_pkg::DATA_W-1:0] prdata,
  output logic                    pready
);
  import falru_pkg::*;

  // Input register.
  logic  stage_valid;
  logic  stage_func;
  key_t  stage_key;

  // Directory state.
  key_t                entry_key [ENTRIES];
  logic [ENTRIES-1:0]  entry_valid;
  rank_t               recency_rank [ENTRIES];
  cnt_t                key_count;
  cap_t                capacity;

  // Next-state values.
  key_t                entry_key_next [ENTRIES];
  logic [ENTRIES-1:0]  entry_valid_next;
  rank_t               recency_rank_next [ENTRIES];
  cnt_t                key_count_next;

  logic  advance;
  logic  rsp_valid_next;

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] lru_match;
  logic [ENTRIES-1:0] evict_vec;
  logic [ENTRIES-1:0] live_vec;
  logic [ENTRIES-1:0] free_vec;
  logic [ENTRIES-1:0] ins_vec;
  logic               any_match;
  logic               do_evict;
  logic               do_insert;
  rank_t              hit_rank;
  rank_t              lru_rank;
  cnt_t               cap_eff;
  key_t               ev_key;
  logic               res_hit;
  logic               res_ev_valid;
  logic               res_rem_err;

  assign advance   = stage_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !stage_valid || advance;
  assign rsp_valid_next = advance || (rsp_valid && !rsp_ready);

  // Clamp the configured capacity into 1..ENTRIES.
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(capacity) > ENTRIES) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  assign lru_rank = rank_t'(key_count - CNT_W'(1));

  // Parallel key and rank match across all entries.
  always_comb begin
    hit_rank = '0;
    ev_key   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]     = entry_valid[i] && (entry_key[i] == stage_key);
      lru_match[i] = entry_valid[i] && (recency_rank[i] == lru_rank);
      if (match[i]) begin
        hit_rank = hit_rank | recency_rank[i];
      end
    end
    any_match = |match;
    do_evict  = (stage_func == FUNC_ACCESS) && !any_match &&
                (key_count >= cap_eff) && (key_count != '0);
    evict_vec = do_evict ? lru_match : '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (evict_vec[i]) begin
        ev_key = ev_key | entry_key[i];
      end
    end
    live_vec  = entry_valid & ~evict_vec;
    free_vec  = ~live_vec;
    // Isolate the lowest free slot.
    ins_vec   = free_vec & (~free_vec + ENTRIES'(1));
    do_insert = (stage_func == FUNC_ACCESS) && !any_match && (free_vec != '0);
  end

  always_comb begin
    entry_valid_next = entry_valid;
    key_count_next   = key_count;
    for (int i = 0; i < ENTRIES; i++) begin
      entry_key_next[i]    = entry_key[i];
      recency_rank_next[i] = recency_rank[i];
    end
    res_hit      = 1'b0;
    res_ev_valid = 1'b0;
    res_rem_err  = 1'b0;
    if (stage_func == FUNC_REMOVE) begin
      if (any_match) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (match[i]) begin
            entry_valid_next[i]  = 1'b0;
            recency_rank_next[i] = '0;
          end else if (entry_valid[i] && recency_rank[i] > hit_rank) begin
            recency_rank_next[i] = recency_rank[i] - rank_t'(1);
          end
        end
        key_count_next = key_count - CNT_W'(1);
      end else begin
        res_rem_err = 1'b1;
      end
    end else if (any_match) begin
      res_hit = 1'b1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (match[i]) begin
          recency_rank_next[i] = '0;
        end else if (entry_valid[i] && recency_rank[i] < hit_rank) begin
          recency_rank_next[i] = recency_rank[i] + rank_t'(1);
        end
      end
    end else begin
      // Miss: at capacity the least recent key leaves first, then the new key takes the
      // lowest free slot at rank zero and every other live key ages by one.
      res_ev_valid = do_evict;
      for (int i = 0; i < ENTRIES; i++) begin
        if (do_insert && ins_vec[i]) begin
          entry_valid_next[i]  = 1'b1;
          entry_key_next[i]    = stage_key;
          recency_rank_next[i] = '0;
        end else if (evict_vec[i]) begin
          entry_valid_next[i]  = 1'b0;
          recency_rank_next[i] = '0;
        end else if (live_vec[i] && do_insert) begin
          recency_rank_next[i] = recency_rank[i] + rank_t'(1);
        end
      end
      key_count_next = key_count - CNT_W'(do_evict) + CNT_W'(do_insert);
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req_ready) begin
      stage_valid <= req_valid;
    end
    if (req_ready && req_valid) begin
      stage_func <= func;
      stage_key  <= key;
    end
  end

  // Directory state.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      key_count   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        recency_rank[i] <= '0;
      end
    end else if (advance) begin
      entry_valid <= entry_valid_next;
      key_count   <= key_count_next;
      for (int i = 0; i < ENTRIES; i++) begin
        recency_rank[i] <= recency_rank_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < ENTRIES; i++) begin
        entry_key[i] <= entry_key_next[i];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_valid_next;
    end
    if (advance) begin
      hit           <= res_hit;
      evicted_valid <= res_ev_valid;
      victim_key    <= res_ev_valid ? ev_key : '0;
      remove_error  <= res_rem_err;
      occupancy     <= key_count_next;
    end
  end

  // Configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[ADDR_W-1:2] == REG_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    if (paddr[ADDR_W-1:2] == REG_CAPACITY) begin
      prdata = DATA_W'(capacity);
    end else begin
      prdata = '0;
    end
  end

  assign pready = 1'b1;

endmodule

// ===== rtl/falru_checker.sv =====
// Port-level checks for the fully associative LRU directory, bound to the top.
`include "assert_macros.svh"

module falru_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    rsp_valid,
  input logic                    rsp_ready,
  input logic                    hit,
  input logic                    evicted_valid,
  input falru_pkg::key_t         victim_key,
  input logic                    remove_error,
  input falru_pkg::cnt_t         occupancy
);
  import falru_pkg::*;

  // A stalled response word keeps its occupancy, victim key and hit flag.
  `CHK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
            rsp_valid && $stable(occupancy) && $stable(victim_key) && $stable(hit))

  // Only a missing access can evict, so an eviction excludes hit and error.
  `CHK_SAME(a_evict_excl, rsp_valid && evicted_valid, !hit && !remove_error)

  // Without an eviction the reported key is zero.
  `CHK_SAME(a_evict_key_zero, rsp_valid && !evicted_valid, victim_key == '0)

  // A failed remove is never a hit.
  `CHK_SAME(a_err_not_hit, rsp_valid && remove_error, !hit)

  // The directory never holds more keys than it has entries.
  `CHK_SAME(a_occ_bound, rsp_valid, occupancy <= CNT_W'(ENTRIES))

endmodule

bind fully_associative_lru_directory falru_checker u_falru_checker (.*);

// ===== tb/tb_fully_associative_lru_directory.sv =====
// Self-checking testbench for the fully associative LRU directory.
module tb_fully_associative_lru_directory;
  timeunit 1ns;
  timeprecision 1ps;

  import falru_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int POOL_MAX    = 128;

  typedef struct {
    logic hit;
    logic ev_valid;
    key_t ev_key;
    logic rem_err;
    cnt_t occ;
  } dir_result_t;

  // Tracks the directory contents and checks every response word in order.
  class lru_directory_tracker;
    key_t        slot_key[ENTRIES];
    bit          slot_used[ENTRIES];
    int unsigned slot_rank[ENTRIES];
    int unsigned held;
    int unsigned capacity;
    int          mismatches;
    dir_result_t pending_responses[$];

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        slot_key[i]  = '0;
        slot_used[i] = 1'b0;
        slot_rank[i] = 0;
      end
      held       = 0;
      capacity   = CAPACITY_RESET;
      mismatches = 0;
    endfunction

    function int pending_count();
      return pending_responses.size();
    endfunction

    // Frees a slot and closes the gap it leaves in the recency order.
    function void drop_slot(int s);
      int unsigned r;
      r = slot_rank[s];
      slot_used[s] = 1'b0;
      slot_rank[s] = 0;
      for (int i = 0; i < ENTRIES; i++)
        if (slot_used[i] && slot_rank[i] > r) slot_rank[i]--;
      if (held > 0) held--;
    endfunction

    function void take_request(logic f, key_t k);
      dir_result_t r;
      int          s;
      int          victim;
      int          free_slot;
      int unsigned limit;
      int unsigned r0;
      r.hit      = 1'b0;
      r.ev_valid = 1'b0;
      r.ev_key   = '0;
      r.rem_err  = 1'b0;
      s = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (s < 0 && slot_used[i] && slot_key[i] == k) s = i;
      if (f == FUNC_REMOVE) begin
        if (s >= 0) drop_slot(s);
        else r.rem_err = 1'b1;
      end else if (s >= 0) begin
        r.hit = 1'b1;
        r0 = slot_rank[s];
        for (int i = 0; i < ENTRIES; i++)
          if (slot_used[i] && slot_rank[i] < r0) slot_rank[i]++;
        slot_rank[s] = 0;
      end else begin
        limit = (capacity == 0) ? 1 : ((capacity > ENTRIES) ? ENTRIES : capacity);
        // The oldest key leaves before the new one takes a slot.
        if (held + 1 > limit && held > 0) begin
          victim = -1;
          for (int i = 0; i < ENTRIES; i++)
            if (victim < 0 && slot_used[i] && slot_rank[i] == held - 1) victim = i;
          if (victim >= 0) begin
            r.ev_valid = 1'b1;
            r.ev_key   = slot_key[victim];
            drop_slot(victim);
          end
        end
        free_slot = -1;
        for (int i = 0; i < ENTRIES; i++)
          if (free_slot < 0 && !slot_used[i]) free_slot = i;
        if (free_slot >= 0) begin
          for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i]) slot_rank[i]++;
          slot_used[free_slot] = 1'b1;
          slot_key[free_slot]  = k;
          slot_rank[free_slot] = 0;
          held++;
        end
      end
      r.occ = cnt_t'(held);
      pending_responses.push_back(r);
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0h, expected %0h", field, got, want);
      mismatches++;
    endtask

    task match_response(logic h, logic ev, key_t ek, logic re, cnt_t occ);
      dir_result_t w;
      if (pending_responses.size() == 0) begin
        report("response word with no request outstanding", 32'(occ), 32'(0));
      end else begin
        w = pending_responses.pop_front();
        if (h !== w.hit) report("hit", 32'(h), 32'(w.hit));
        if (ev !== w.ev_valid) report("evicted_valid", 32'(ev), 32'(w.ev_valid));
        if (ek !== w.ev_key) report("victim_key", 32'(ek), 32'(w.ev_key));
        if (re !== w.rem_err) report("remove_error", 32'(re), 32'(w.rem_err));
        if (occ !== w.occ) report("occupancy", 32'(occ), 32'(w.occ));
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_ready;
  logic              func = FUNC_ACCESS;
  key_t              key = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  logic              hit;
  logic              evicted_valid;
  key_t              victim_key;
  logic              remove_error;
  cnt_t              occupancy;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  lru_directory_tracker tracker;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int   hold_left = 0;
  int   cycle_count = 0;
  key_t key_pool[POOL_MAX];

  fully_associative_lru_directory uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .func(func), .key(key),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .hit(hit),
    .evicted_valid(evicted_valid), .victim_key(victim_key),
    .remove_error(remove_error), .occupancy(occupancy),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("fully_associative_lru_directory verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) tracker.take_request(func, key);
      if (rsp_valid && rsp_ready)
        tracker.match_response(hit, evicted_valid, victim_key, remove_error, occupancy);
    end
  end

  // Offers one word and returns at the edge where it is accepted.
  task send_word(input logic f, input key_t k);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    func      <= f;
    key       <= k;
    do @(posedge clk); while (!req_ready);
  endtask

  task write_capacity(input int unsigned value);
    req_valid <= 1'b0;
    // One edge first so that the word accepted last is already tracked.
    @(posedge clk);
    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.capacity = value & 32'h7f;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly keys from a small pool so that hits and evictions are common.
  task run_segment(input int unsigned cap, input int pool_n, input int count,
                   input int s_idle, input int r_idle, input bit squeeze);
    logic f;
    key_t k;
    write_capacity(cap);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    if (squeeze) hold_req <= ~hold_req;
    for (int n = 0; n < count; n++) begin
      f = ($urandom_range(99) < 22) ? FUNC_REMOVE : FUNC_ACCESS;
      if ($urandom_range(99) < 10) k = key_t'($urandom);
      else k = key_pool[$urandom_range(pool_n - 1)];
      send_word(f, k);
    end
    req_valid <= 1'b0;
  endtask

  initial begin
    tracker = new();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_MAX; i++) key_pool[i] = key_t'($urandom);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words at the reset capacity.
    send_word(FUNC_ACCESS, 32'h0000_0000);
    send_word(FUNC_ACCESS, 32'hFFFF_FFFF);
    send_word(FUNC_ACCESS, 32'h0000_0000);
    send_word(FUNC_REMOVE, 32'h1234_5678);
    send_word(FUNC_REMOVE, 32'hFFFF_FFFF);
    send_word(FUNC_REMOVE, 32'hFFFF_FFFF);
    send_word(FUNC_ACCESS, 32'h8000_0000);
    send_word(FUNC_ACCESS, 32'h0000_0001);
    send_word(FUNC_ACCESS, 32'h7FFF_FFFF);
    // Capacity now below the occupancy: each miss evicts exactly one key.
    write_capacity(2);
    send_word(FUNC_ACCESS, 32'h5555_5555);
    send_word(FUNC_ACCESS, 32'hAAAA_AAAA);
    send_word(FUNC_ACCESS, 32'h5555_5555);
    send_word(FUNC_REMOVE, 32'h0000_0000);
    send_word(FUNC_ACCESS, 32'h0000_0000);
    write_capacity(1);
    send_word(FUNC_ACCESS, 32'h0000_0001);
    send_word(FUNC_ACCESS, 32'h0000_0001);
    send_word(FUNC_REMOVE, 32'h0000_0001);
    send_word(FUNC_REMOVE, 32'h0000_0001);
    send_word(FUNC_ACCESS, 32'hFFFF_FFFF);
    send_word(FUNC_ACCESS, 32'h0000_0000);
    req_valid <= 1'b0;

    run_segment(4, 8, 80, 29, 83, 1'b0);
    run_segment(1, 4, 60, 29, 83, 1'b0);
    run_segment(64, 96, 100, 29, 83, 1'b0);
    run_segment(0, 3, 50, 83, 29, 1'b0);
    run_segment(127, 80, 120, 83, 29, 1'b0);
    run_segment(16, 24, 60, 83, 29, 1'b0);
    run_segment(64, 70, 100, 0, 0, 1'b1);
    run_segment(5, 12, 60, 0, 0, 1'b0);
    run_segment(33, 48, 70, 0, 0, 1'b0);

    @(posedge clk);
    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_count() == 0) begin
      $display("fully_associative_lru_directory verification clean");
    end else begin
      $display("fully_associative_lru_directory verification failed");
    end
    $finish;
  end

endmodule
